@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define PPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ppc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perforated plate classifier package
// Shared codes, fixed widths and the controller state type.
// ----------------------------------------------------------------------------
package ppc_pkg;

    // Radius field width, unsigned Q7.16.
    localparam int RADIUS_BITS = 23;

    // Item kinds.
    localparam logic [1:0] KIND_ADD_CIRCLE = 2'd0;
    localparam logic [1:0] KIND_ADD_OVAL   = 2'd1;
    localparam logic [1:0] KIND_QUERY      = 2'd2;

    // Register stages in the hole evaluation pipeline.
    localparam int PIPE_DEPTH = 6;
    localparam int DRAIN_W    = 3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

@@ rtl/ppc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hole storage cell
// Holds one hole entry with its valid bit and passes it to the next cell
// whenever the chain shifts.
// ----------------------------------------------------------------------------
module ppc_cell #(
    parameter int W = 120
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic         din_valid,
    input  logic [W-1:0] din,
    output logic         dout_valid,
    output logic [W-1:0] dout
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    // The valid bit is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= din_valid;
        end
    end

    // The hole fields need no reset.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    assign dout_valid = valid_reg;
    assign dout       = data_reg;

endmodule

@@ rtl/ppc_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hole evaluation pipeline
// Tests one hole against the query point per cycle: circle tests at both
// ends and, for ovals, the band test d*d <= L^2 * R^2, over six register stages.
// ----------------------------------------------------------------------------
module ppc_eval #(
    parameter int COORD_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                oval,
    input  logic [ppc_pkg::RADIUS_BITS-1:0]     radius,
    input  logic signed [COORD_BITS-1:0]        cx,
    input  logic signed [COORD_BITS-1:0]        cy,
    input  logic signed [COORD_BITS-1:0]        ex,
    input  logic signed [COORD_BITS-1:0]        ey,
    input  logic signed [COORD_BITS-1:0]        px,
    input  logic signed [COORD_BITS-1:0]        py,
    output logic                                out_valid,
    output logic                                in_hole
);

    localparam int RB  = ppc_pkg::RADIUS_BITS;
    localparam int D   = COORD_BITS + 1;
    localparam int SW  = 2 * D;
    localparam int MW  = 2 * D + 1;
    localparam int H   = (MW + 1) / 2;
    localparam int LH  = (MW + 1) / 2;
    localparam int RRW = 2 * RB;
    localparam int FW  = ((MW > RRW) ? MW : RRW) + 1;
    localparam int DQW = 2 * MW;
    localparam int LMW = MW + RRW;

    // Valid bits of the six stages.
    logic [ppc_pkg::PIPE_DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ppc_pkg::PIPE_DEPTH-2:0], in_valid};
        end
    end

    // Stage 1: coordinate differences.
    logic signed [D-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [D-1:0] a_reg, b_reg, c_reg, e_reg;
    logic [RB-1:0]       r1_rad_reg;
    logic                oval1_reg;

    always_ff @(posedge clk)
    begin
        dx1_reg    <= D'(px) - D'(cx);
        dy1_reg    <= D'(py) - D'(cy);
        dx2_reg    <= D'(px) - D'(ex);
        dy2_reg    <= D'(py) - D'(ey);
        a_reg      <= D'(ex) - D'(cx);
        b_reg      <= D'(ey) - D'(py);
        c_reg      <= D'(ex) - D'(px);
        e_reg      <= D'(ey) - D'(cy);
        r1_rad_reg <= radius;
        oval1_reg  <= oval;
    end

    // Stage 2: squares and cross products.
    logic signed [SW-1:0] sq_dx1_next, sq_dy1_next, sq_dx2_next, sq_dy2_next;
    logic signed [SW-1:0] sq_a_next, sq_e_next, ab_next, ce_next;
    logic signed [SW-1:0] sq_dx1_reg, sq_dy1_reg, sq_dx2_reg, sq_dy2_reg;
    logic signed [SW-1:0] sq_a_reg, sq_e_reg, ab_reg, ce_reg;
    logic [RRW-1:0]       rr2_reg;
    logic                 oval2_reg;

    assign sq_dx1_next = dx1_reg * dx1_reg;
    assign sq_dy1_next = dy1_reg * dy1_reg;
    assign sq_dx2_next = dx2_reg * dx2_reg;
    assign sq_dy2_next = dy2_reg * dy2_reg;
    assign sq_a_next   = a_reg * a_reg;
    assign sq_e_next   = e_reg * e_reg;
    assign ab_next     = a_reg * b_reg;
    assign ce_next     = c_reg * e_reg;

    always_ff @(posedge clk)
    begin
        sq_dx1_reg <= sq_dx1_next;
        sq_dy1_reg <= sq_dy1_next;
        sq_dx2_reg <= sq_dx2_next;
        sq_dy2_reg <= sq_dy2_next;
        sq_a_reg   <= sq_a_next;
        sq_e_reg   <= sq_e_next;
        ab_reg     <= ab_next;
        ce_reg     <= ce_next;
        rr2_reg    <= RRW'(r1_rad_reg) * RRW'(r1_rad_reg);
        oval2_reg  <= oval1_reg;
    end

    // Stage 3: distance sums, end circle tests and the cross product magnitude.
    logic [MW-1:0]        r1_dist, r2_dist, len_sq;
    logic [FW-1:0]        far_lim;
    logic signed [MW-1:0] d_val;
    logic [MW-1:0]        d_mag;
    logic                 circ_hit;
    logic                 far_ok;

    assign r1_dist = MW'(unsigned'(sq_dx1_reg)) + MW'(unsigned'(sq_dy1_reg));
    assign r2_dist = MW'(unsigned'(sq_dx2_reg)) + MW'(unsigned'(sq_dy2_reg));
    assign len_sq  = MW'(unsigned'(sq_a_reg)) + MW'(unsigned'(sq_e_reg));
    assign far_lim = FW'(len_sq) + FW'(rr2_reg);
    assign d_val   = MW'(ab_reg) - MW'(ce_reg);
    assign d_mag   = d_val[MW-1] ? MW'(-d_val) : MW'(d_val);
    assign circ_hit = (FW'(r1_dist) <= FW'(rr2_reg))
                      || (oval2_reg && (FW'(r2_dist) <= FW'(rr2_reg)));
    assign far_ok  = (FW'(r1_dist) <= far_lim) && (FW'(r2_dist) <= far_lim);

    logic          circ3_reg, band3_reg;
    logic [MW-1:0] dmag3_reg, len3_reg;
    logic [RRW-1:0] rr3_reg;

    always_ff @(posedge clk)
    begin
        circ3_reg <= circ_hit;
        band3_reg <= oval2_reg && far_ok;
        dmag3_reg <= d_mag;
        len3_reg  <= len_sq;
        rr3_reg   <= rr2_reg;
    end

    // Stage 4: partial products of d*d and L^2 * R^2.
    logic [DQW-1:0] dll_reg, dlh_reg, dhh_reg;
    logic [LMW-1:0] lrl_l_reg, lrl_h_reg, lrh_l_reg, lrh_h_reg;
    logic           circ4_reg, band4_reg;

    always_ff @(posedge clk)
    begin
        dll_reg   <= DQW'(dmag3_reg[H-1:0]) * DQW'(dmag3_reg[H-1:0]);
        dlh_reg   <= DQW'(dmag3_reg[H-1:0]) * DQW'(dmag3_reg[MW-1:H]);
        dhh_reg   <= DQW'(dmag3_reg[MW-1:H]) * DQW'(dmag3_reg[MW-1:H]);
        lrl_l_reg <= LMW'(len3_reg[LH-1:0]) * LMW'(rr3_reg[RB-1:0]);
        lrl_h_reg <= LMW'(len3_reg[MW-1:LH]) * LMW'(rr3_reg[RB-1:0]);
        lrh_l_reg <= LMW'(len3_reg[LH-1:0]) * LMW'(rr3_reg[RRW-1:RB]);
        lrh_h_reg <= LMW'(len3_reg[MW-1:LH]) * LMW'(rr3_reg[RRW-1:RB]);
        circ4_reg <= circ3_reg;
        band4_reg <= band3_reg;
    end

    // Stage 5: assemble d*d and the band limit.
    logic [DQW-1:0] dsq_reg;
    logic [LMW-1:0] lim_reg;
    logic           circ5_reg, band5_reg;

    always_ff @(posedge clk)
    begin
        dsq_reg   <= (dhh_reg << (2 * H)) + (dlh_reg << (H + 1)) + dll_reg;
        lim_reg   <= lrl_l_reg + (lrl_h_reg << LH) + (lrh_l_reg << RB)
                     + (lrh_h_reg << (LH + RB));
        circ5_reg <= circ4_reg;
        band5_reg <= band4_reg;
    end

    // Stage 6: final decision.
    logic in_hole_reg;

    always_ff @(posedge clk)
    begin
        in_hole_reg <= circ5_reg || (band5_reg && (dsq_reg <= DQW'(lim_reg)));
    end

    assign out_valid = vld_reg[ppc_pkg::PIPE_DEPTH-1];
    assign in_hole   = in_hole_reg;

endmodule

@@ rtl/perforated_plate_point_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perforated plate point classifier
// Keeps a table of circular and oval holes in a ring of storage cells and
// tells whether a query point lies in the plate material.
// ----------------------------------------------------------------------------
// Add items and unused kinds: result registered in the cycle after acceptance.
// Query items: the scan state rotates the whole cell ring through the evaluation
// pipeline, then the drain state waits for it to empty and the result is registered.
// One item at a time; the next item is accepted once the result register is free.
// Reset empties the hole table and clears all handshake state.
module perforated_plate_point_classifier_top #(
    parameter int MAX_HOLES  = 16,
    parameter int COORD_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          kind,
    input  logic [ppc_pkg::RADIUS_BITS-1:0]     radius,
    input  logic signed [COORD_BITS-1:0]        center_x,
    input  logic signed [COORD_BITS-1:0]        center_y,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    input  logic signed [COORD_BITS-1:0]        point_x,
    input  logic signed [COORD_BITS-1:0]        point_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                in_material,
    output logic                                status
);

    localparam int RB  = ppc_pkg::RADIUS_BITS;
    localparam int C   = COORD_BITS;
    localparam int HW  = 1 + RB + 4 * C;
    localparam int HCW = $clog2(MAX_HOLES + 1);
    localparam int SCW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int DW  = ppc_pkg::DRAIN_W;

    ppc_pkg::state_t state_reg, state_next;
    logic [HCW-1:0]  hole_count_reg, hole_count_next;
    logic [SCW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [DW-1:0]   drain_cnt_reg, drain_cnt_next;
    logic            hit_reg, hit_next;
    logic            out_valid_reg, out_valid_next;
    logic            in_material_reg, in_material_next;
    logic            status_reg, status_next;
    logic signed [C-1:0] pt_x_reg, pt_y_reg;

    logic            in_acc;
    logic            out_acc;
    logic            full;
    logic            shift;
    logic            add_en;
    logic            ev_valid;
    logic            ev_inside;
    logic [HW-1:0]   new_hole;

    logic [MAX_HOLES-1:0] cv;
    logic [HW-1:0]        cd [MAX_HOLES];

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign full    = (hole_count_reg == HCW'(MAX_HOLES));
    assign in_stall = (state_reg != ppc_pkg::ST_IDLE) || (out_valid_reg && out_stall);

    // A new hole; a circle stores its centre as both ends.
    assign add_en = in_acc && !full
                    && ((kind == ppc_pkg::KIND_ADD_CIRCLE) || (kind == ppc_pkg::KIND_ADD_OVAL));
    assign new_hole = (kind == ppc_pkg::KIND_ADD_OVAL)
                      ? {1'b1, radius, center_x, center_y, end_x, end_y}
                      : {1'b0, radius, center_x, center_y, center_x, center_y};

    // The ring shifts once per add and once per scan cycle.
    assign shift = add_en || (state_reg == ppc_pkg::ST_SCAN);

    // Storage ring: cell zero takes a new hole or the entry leaving the last cell.
    generate
        for (genvar g = 0; g < MAX_HOLES; g++)
        begin : g_cell
            logic          din_v;
            logic [HW-1:0] din_d;
            if (g == 0)
            begin : g_head
                assign din_v = add_en ? 1'b1 : cv[MAX_HOLES-1];
                assign din_d = add_en ? new_hole : cd[MAX_HOLES-1];
            end
            else
            begin : g_body
                assign din_v = cv[g-1];
                assign din_d = cd[g-1];
            end
            ppc_cell #(
                .W(HW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .din_valid  (din_v),
                .din        (din_d),
                .dout_valid (cv[g]),
                .dout       (cd[g])
            );
        end
    endgenerate

    // Evaluation of the entry leaving the ring.
    ppc_eval #(
        .COORD_BITS(C)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  ((state_reg == ppc_pkg::ST_SCAN) && cv[MAX_HOLES-1]),
        .oval      (cd[MAX_HOLES-1][HW-1]),
        .radius    (cd[MAX_HOLES-1][HW-2 -: RB]),
        .cx        (cd[MAX_HOLES-1][4*C-1 -: C]),
        .cy        (cd[MAX_HOLES-1][3*C-1 -: C]),
        .ex        (cd[MAX_HOLES-1][2*C-1 -: C]),
        .ey        (cd[MAX_HOLES-1][C-1:0]),
        .px        (pt_x_reg),
        .py        (pt_y_reg),
        .out_valid (ev_valid),
        .in_hole   (ev_inside)
    );

    // Controller next state.
    always_comb
    begin
        state_next       = state_reg;
        hole_count_next  = hole_count_reg;
        scan_cnt_next    = scan_cnt_reg;
        drain_cnt_next   = drain_cnt_reg;
        hit_next         = hit_reg || (ev_valid && ev_inside);
        out_valid_next   = out_acc ? 1'b0 : out_valid_reg;
        in_material_next = in_material_reg;
        status_next      = status_reg;
        unique case (state_reg)
            ppc_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (kind) inside
                        ppc_pkg::KIND_ADD_CIRCLE, ppc_pkg::KIND_ADD_OVAL:
                        begin
                            out_valid_next   = 1'b1;
                            in_material_next = 1'b0;
                            status_next      = full;
                            if (!full)
                            begin
                                hole_count_next = hole_count_reg + HCW'(1);
                            end
                        end
                        ppc_pkg::KIND_QUERY:
                        begin
                            state_next    = ppc_pkg::ST_SCAN;
                            scan_cnt_next = '0;
                            hit_next      = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next   = 1'b1;
                            in_material_next = 1'b0;
                            status_next      = 1'b0;
                        end
                    endcase
                end
            end
            ppc_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + SCW'(1);
                if (scan_cnt_reg == SCW'(MAX_HOLES - 1))
                begin
                    state_next     = ppc_pkg::ST_DRAIN;
                    drain_cnt_next = '0;
                end
            end
            ppc_pkg::ST_DRAIN:
            begin
                drain_cnt_next = drain_cnt_reg + DW'(1);
                if (drain_cnt_reg == DW'(ppc_pkg::PIPE_DEPTH - 1))
                begin
                    state_next       = ppc_pkg::ST_IDLE;
                    out_valid_next   = 1'b1;
                    in_material_next = !(hit_reg || (ev_valid && ev_inside));
                    status_next      = 1'b0;
                end
            end
            default:
            begin
                state_next = ppc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppc_pkg::ST_IDLE;
            hole_count_reg <= '0;
            scan_cnt_reg   <= '0;
            drain_cnt_reg  <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hole_count_reg <= hole_count_next;
            scan_cnt_reg   <= scan_cnt_next;
            drain_cnt_reg  <= drain_cnt_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result and query point registers.
    always_ff @(posedge clk)
    begin
        in_material_reg <= in_material_next;
        status_reg      <= status_next;
        if (in_acc)
        begin
            pt_x_reg <= point_x;
            pt_y_reg <= point_y;
        end
    end

    assign out_valid   = out_valid_reg;
    assign in_material = in_material_reg;
    assign status      = status_reg;

endmodule

@@ rtl/ppc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the classifier ports for handshake and result rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] kind,
    input logic       out_valid,
    input logic       out_stall,
    input logic       in_material,
    input logic       status
);

    // A stalled result transaction stays offered.
    `PPC_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `PPC_ASSERT(a_out_stable, clk, rst_n, (out_valid && out_stall) |=> ($stable(in_material) && $stable(status)), "result changed while stalled")

    // An accepted add answers in the next cycle with in_material low.
    `PPC_ASSERT(a_add_result, clk, rst_n, (in_valid && !in_stall && ((kind == ppc_pkg::KIND_ADD_CIRCLE) || (kind == ppc_pkg::KIND_ADD_OVAL))) |=> (out_valid && !in_material), "add result missing")

    // No new transaction is taken while a result is held back.
    `PPC_ASSERT(a_in_blocked, clk, rst_n, (out_valid && out_stall) |-> in_stall, "input taken while result stalled")

    // The full flag only comes with in_material low, as on an add result.
    `PPC_ASSERT(a_status_add, clk, rst_n, (out_valid && status) |-> !in_material, "full flag on a query result")

endmodule

bind perforated_plate_point_classifier_top ppc_checker u_ppc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .in_material (in_material),
    .status      (status)
);
